/* rtl/cpuutil_pkg.sv */
// Shared types for the CPU usage block: controller states, command and status groups.
package cpuutil_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM1,
      ST_SUM2,
      ST_SUM3,
      ST_DIFF,
      ST_BUSY,
      ST_DIV,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic sum1;
      logic sum2;
      logic sum3;
      logic diff;
      logic busy;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic skip;
   } sts_type;

endpackage

/* rtl/cpuutil_if.sv */
// Valid/ready channel interfaces for snapshot items and result items.
interface cpuutil_req_if #(
   parameter int CNT_W = 48
);
   logic             valid;
   logic             ready;
   logic             counters_valid;
   logic [CNT_W-1:0] user_ticks;
   logic [CNT_W-1:0] nice_ticks;
   logic [CNT_W-1:0] system_ticks;
   logic [CNT_W-1:0] idle_ticks;
   logic [CNT_W-1:0] iowait_ticks;

   modport source (
      output valid, counters_valid, user_ticks, nice_ticks, system_ticks,
             idle_ticks, iowait_ticks,
      input  ready
   );
   modport sink (
      input  valid, counters_valid, user_ticks, nice_ticks, system_ticks,
             idle_ticks, iowait_ticks,
      output ready
   );
endinterface

interface cpuutil_rsp_if #(
   parameter int FRAC_W = 16
);
   logic            valid;
   logic            ready;
   logic [FRAC_W:0] busy_fraction;
   logic            computed;

   modport source (
      output valid, busy_fraction, computed,
      input  ready
   );
   modport sink (
      input  valid, busy_fraction, computed,
      output ready
   );
endinterface

/* rtl/cpuutil_dp.sv */
// Datapath: tick sums, deltas against the previous snapshot, restoring divider, result register.
module cpuutil_dp
   import cpuutil_pkg::*;
#(
   parameter int COUNTER_BITS  = 48,
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [COUNTER_BITS-1:0] user_ticks,
   input  logic [COUNTER_BITS-1:0] nice_ticks,
   input  logic [COUNTER_BITS-1:0] system_ticks,
   input  logic [COUNTER_BITS-1:0] idle_ticks,
   input  logic [COUNTER_BITS-1:0] iowait_ticks,
   output logic [FRACTION_BITS:0]  busy_fraction,
   output logic                    computed
);

   localparam int CB = COUNTER_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int TW = CB + 3;
   localparam int IW = CB + 1;

   logic [CB-1:0] user_ff, user_in;
   logic [CB-1:0] nice_ff, nice_in;
   logic [CB-1:0] sys_ff, sys_in;
   logic [CB-1:0] idl_ff, idl_in;
   logic [CB-1:0] iow_ff, iow_in;
   logic [IW-1:0] idle_ff, idle_in;
   logic [CB+1:0] part_ff, part_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] prev_total_ff, prev_total_in;
   logic [IW-1:0] prev_idle_ff, prev_idle_in;
   logic          have_prev_ff, have_prev_in;
   logic          skip_ff, skip_in;
   logic          back_ff, back_in;
   logic [IW-1:0] didle_ff, didle_in;
   logic [TW-1:0] den_ff, den_in;
   logic          one_ff, one_in;
   logic [TW-1:0] r_ff, r_in;
   logic [FB-1:0] q_ff, q_in;
   logic [FB:0]   frac_ff, frac_in;
   logic          comp_ff, comp_in;

   logic [TW:0]   dt;
   logic [IW:0]   di;
   logic [TW:0]   bz;
   logic [TW:0]   r2;
   logic [TW:0]   rsub;
   logic          ge;

   assign dt   = {1'b0, total_ff} - {1'b0, prev_total_ff};
   assign di   = {1'b0, idle_ff} - {1'b0, prev_idle_ff};
   assign bz   = {1'b0, den_ff} - (TW+1)'(didle_ff);
   assign r2   = {r_ff, 1'b0};
   assign rsub = r2 - {1'b0, den_ff};
   assign ge   = r2 >= {1'b0, den_ff};

   always_comb begin
      user_in       = user_ff;
      nice_in       = nice_ff;
      sys_in        = sys_ff;
      idl_in        = idl_ff;
      iow_in        = iow_ff;
      idle_in       = idle_ff;
      part_in       = part_ff;
      total_in      = total_ff;
      prev_total_in = prev_total_ff;
      prev_idle_in  = prev_idle_ff;
      have_prev_in  = have_prev_ff;
      skip_in       = skip_ff;
      back_in       = back_ff;
      didle_in      = didle_ff;
      den_in        = den_ff;
      one_in        = one_ff;
      r_in          = r_ff;
      q_in          = q_ff;
      frac_in       = frac_ff;
      comp_in       = comp_ff;

      if (cmd.load) begin
         user_in = user_ticks;
         nice_in = nice_ticks;
         sys_in  = system_ticks;
         idl_in  = idle_ticks;
         iow_in  = iowait_ticks;
      end
      if (cmd.clear) begin
         frac_in = '0;
         comp_in = 1'b0;
      end
      if (cmd.sum1) begin
         idle_in = {1'b0, idl_ff} + {1'b0, iow_ff};
         part_in = {2'b00, user_ff} + {2'b00, nice_ff};
      end
      if (cmd.sum2) begin
         part_in = part_ff + {2'b00, sys_ff};
      end
      if (cmd.sum3) begin
         total_in = {1'b0, part_ff} + TW'(idle_ff);
      end
      if (cmd.diff) begin
         // state always takes the new snapshot, whether or not a fraction follows
         skip_in       = !have_prev_ff || dt[TW] || (dt[TW-1:0] == '0);
         den_in        = dt[TW-1:0];
         back_in       = di[IW];
         didle_in      = di[IW-1:0];
         prev_total_in = total_ff;
         prev_idle_in  = idle_ff;
         have_prev_in  = 1'b1;
      end
      if (cmd.busy) begin
         // idle went backwards or did not move: fully busy
         one_in = back_ff || (didle_ff == '0);
         r_in   = (bz[TW] || (bz == '0)) ? '0 : bz[TW-1:0];
         q_in   = '0;
      end
      if (cmd.div_step) begin
         r_in = ge ? rsub[TW-1:0] : r2[TW-1:0];
         q_in = {q_ff[FB-2:0], ge};
      end
      if (cmd.finish) begin
         if (skip_ff) begin
            frac_in = '0;
         end else if (one_ff) begin
            frac_in = {1'b1, {FB{1'b0}}};
         end else begin
            frac_in = {1'b0, q_ff};
         end
         comp_in = !skip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_total_ff <= '0;
         prev_idle_ff  <= '0;
         have_prev_ff  <= 1'b0;
      end else begin
         prev_total_ff <= prev_total_in;
         prev_idle_ff  <= prev_idle_in;
         have_prev_ff  <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      user_ff  <= user_in;
      nice_ff  <= nice_in;
      sys_ff   <= sys_in;
      idl_ff   <= idl_in;
      iow_ff   <= iow_in;
      idle_ff  <= idle_in;
      part_ff  <= part_in;
      total_ff <= total_in;
      skip_ff  <= skip_in;
      back_ff  <= back_in;
      didle_ff <= didle_in;
      den_ff   <= den_in;
      one_ff   <= one_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
      frac_ff  <= frac_in;
      comp_ff  <= comp_in;
   end

   assign sts.skip      = skip_ff;
   assign busy_fraction = frac_ff;
   assign computed      = comp_ff;

endmodule

/* rtl/cpuutil_ctrl.sv */
// Controller: sequences sums, deltas and divider steps, and runs the channel handshakes.
module cpuutil_ctrl
   import cpuutil_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    in_good,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam int CW = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          last;

   assign last = cnt_ff == CW'(FRACTION_BITS - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = in_good ? ST_SUM1 : ST_DONE;
            end
         end
         ST_SUM1:   state_in = ST_SUM2;
         ST_SUM2:   state_in = ST_SUM3;
         ST_SUM3:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_BUSY;
         ST_BUSY:   state_in = sts.skip ? ST_FINISH : ST_DIV;
         ST_DIV: begin
            if (last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_DONE;
         ST_DONE: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            in_ready  = 1'b1;
            cmd.load  = in_valid;
            cmd.clear = in_valid && !in_good;
         end
         ST_SUM1:   cmd.sum1 = 1'b1;
         ST_SUM2:   cmd.sum2 = 1'b1;
         ST_SUM3:   cmd.sum3 = 1'b1;
         ST_DIFF:   cmd.diff = 1'b1;
         ST_BUSY: begin
            cmd.busy = 1'b1;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
         end
         ST_FINISH: cmd.finish = 1'b1;
         ST_DONE:   out_valid  = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/cpu_usage_from_tick_counters_core.sv */
// Top level: CPU busy fraction from cumulative tick counter snapshots.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     counters_valid, user/nice/system/idle/iowait_ticks
//   rsp      out  valid/ready     busy_fraction (Q1.FRACTION_BITS), computed
//
// One item at a time. A valid snapshot passes through states SUM1, SUM2, SUM3 (sums),
// DIFF (deltas), BUSY (divider setup), DIV (one restoring divider step per quotient
// bit, skipped when no fraction follows) and FINISH (registers the result) before
// its result shows. The next item is taken only after the result is accepted.
// An invalid snapshot answers in the next cycle. req.ready is high only when idle;
// the result holds while rsp.ready is low. Reset clears the stored snapshot.
module cpu_usage_from_tick_counters_core
   import cpuutil_pkg::*;
#(
   parameter int COUNTER_BITS  = 48,
   parameter int FRACTION_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   cpuutil_req_if.sink   req,
   cpuutil_rsp_if.source rsp
);

   cmd_type cmd;
   sts_type sts;

   cpuutil_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_good  (req.counters_valid),
      .in_ready (req.ready),
      .out_valid(rsp.valid),
      .out_ready(rsp.ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   cpuutil_dp #(
      .COUNTER_BITS (COUNTER_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .user_ticks   (req.user_ticks),
      .nice_ticks   (req.nice_ticks),
      .system_ticks (req.system_ticks),
      .idle_ticks   (req.idle_ticks),
      .iowait_ticks (req.iowait_ticks),
      .busy_fraction(rsp.busy_fraction),
      .computed     (rsp.computed)
   );

endmodule

/* rtl/cpuutil_checker.sv */
// Port-level checks for the CPU usage block, bound to the top level.
module cpuutil_checker #(
   parameter int FRACTION_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_counters_valid,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [FRACTION_BITS:0] rsp_busy_fraction,
   input logic                   rsp_computed
);

   // fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_busy_fraction <= {1'b1, {FRACTION_BITS{1'b0}}})
      else $error("busy_fraction above one");

   a_default_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_computed) |-> rsp_busy_fraction == '0)
      else $error("default result is not zero");

   // one item in flight: never ready for input while a result is shown
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");

   a_invalid_fast: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_counters_valid) |=> (rsp_valid && !rsp_computed))
      else $error("invalid snapshot not answered next cycle");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_busy_fraction) && $stable(rsp_computed)))
      else $error("stalled result changed");

endmodule

bind cpu_usage_from_tick_counters_core cpuutil_checker #(
   .FRACTION_BITS(FRACTION_BITS)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_counters_valid(req.counters_valid),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_busy_fraction (rsp.busy_fraction),
   .rsp_computed      (rsp.computed)
);

/* tb/testbench.sv */
// Self-checking testbench for the CPU busy-share block: directed table, then random snapshots.
module testbench;

   localparam int CNT_W  = 48;
   localparam int FRAC_W = 16;

   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic    counters_valid;
      cnt_type user_ticks;
      cnt_type nice_ticks;
      cnt_type system_ticks;
      cnt_type idle_ticks;
      cnt_type iowait_ticks;
   } snap_type;

   typedef struct packed {
      logic [FRAC_W:0] busy_fraction;
      logic            computed;
   } share_type;

   // typed = 1: the table gives the result, otherwise the predictor does
   typedef struct packed {
      logic      typed;
      share_type share;
   } want_type;

   typedef struct packed {
      snap_type snap;
      want_type want;
   } row_type;

   localparam cnt_type MAXC = '1;
   localparam cnt_type HALF = 48'h8000_0000_0000;
   localparam cnt_type P55  = 48'h5555_5555_5555;
   localparam cnt_type PAA  = 48'hAAAA_AAAA_AAAA;
   localparam logic [FRAC_W:0] FULL = {1'b1, {FRAC_W{1'b0}}};

   localparam int PLAN_N = 23;
   localparam row_type PLAN [PLAN_N] = '{
      '{'{1'b0, MAXC, MAXC, MAXC, MAXC, MAXC}, '{1'b1, '{17'd0, 1'b0}}},  // invalid, no history
      '{'{1'b1, 0, 0, 0, 0, 0},                '{1'b1, '{17'd0, 1'b0}}},  // first snapshot
      '{'{1'b1, 0, 0, 0, 0, 0},                '{1'b1, '{17'd0, 1'b0}}},  // dtotal zero
      '{'{1'b1, 100, 0, 0, 0, 0},              '{1'b1, '{FULL, 1'b1}}},   // fully busy
      '{'{1'b1, 100, 0, 0, 100, 0},            '{1'b1, '{17'd0, 1'b1}}},  // fully idle
      '{'{1'b1, 150, 0, 0, 150, 0},            '{1'b1, '{17'd32768, 1'b1}}},
      '{'{1'b0, 1, P55, P55, P55, P55},        '{1'b1, '{17'd0, 1'b0}}},  // invalid keeps state
      '{'{1'b1, 250, 0, 0, 250, 0},            '{1'b1, '{17'd32768, 1'b1}}},
      '{'{1'b1, 10, 0, 0, 10, 0},              '{1'b1, '{17'd0, 1'b0}}},  // total went down
      '{'{1'b1, 5, 0, 0, 30, 0},               '{1'b1, '{17'd0, 1'b1}}},  // idle grew past total
      '{'{1'b1, 100, 0, 0, 0, 0},              '{1'b1, '{FULL, 1'b1}}},   // idle went backwards
      '{'{1'b1, 101, 0, 0, 2, 0},              '{1'b1, '{17'd21845, 1'b1}}}, // truncation
      '{'{1'b1, 102, 1, 1, 2, 1},              '{1'b1, '{17'd49152, 1'b1}}},
      '{'{1'b1, 65638, 1, 1, 2, 2},            '{1'b1, '{17'd65535, 1'b1}}}, // just under one
      '{'{1'b1, MAXC, MAXC, MAXC, MAXC, MAXC}, '{1'b0, '{17'd0, 1'b0}}},
      '{'{1'b1, MAXC, MAXC, MAXC, 0, 0},       '{1'b1, '{17'd0, 1'b0}}},
      '{'{1'b1, 0, 0, 0, MAXC, MAXC},          '{1'b1, '{17'd0, 1'b0}}},
      '{'{1'b1, MAXC, MAXC, MAXC, MAXC, MAXC}, '{1'b1, '{FULL, 1'b1}}},
      '{'{1'b1, 0, 0, 0, 0, 0},                '{1'b1, '{17'd0, 1'b0}}},
      '{'{1'b1, MAXC, 0, 0, 0, 0},             '{1'b1, '{FULL, 1'b1}}},
      '{'{1'b1, MAXC, 0, 0, HALF, 0},          '{1'b1, '{17'd0, 1'b1}}},
      '{'{1'b0, 0, 0, 0, 0, 0},                '{1'b1, '{17'd0, 1'b0}}},
      '{'{1'b1, MAXC, 1, P55, HALF, PAA},      '{1'b0, '{17'd0, 1'b0}}}
   };

   localparam int RANDOM_N = 1350;

   logic clock;
   logic reset;

   cpuutil_req_if #(.CNT_W(CNT_W))   req_bus ();
   cpuutil_rsp_if #(.FRAC_W(FRAC_W)) rsp_bus ();

   cpu_usage_from_tick_counters_core #(
      .COUNTER_BITS  (CNT_W),
      .FRACTION_BITS (FRAC_W)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // predictor state: last valid snapshot
   logic [CNT_W+2:0] last_total;
   logic [CNT_W:0]   last_idle;
   logic             have_last;

   share_type busy_share_q [$];
   want_type  table_want_q [$];
   int        mismatches   = 0;
   int        results_seen = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: mismatch in %s at %0t: got %0d, want %0d", what, $realtime, got, want);
      mismatches++;
   endtask

   function automatic share_type predict_busy_share(input snap_type s);
      logic [CNT_W+2:0] cur_total;
      logic [CNT_W+2:0] delta_total;
      logic [CNT_W+2:0] busy;
      logic [CNT_W+3:0] rem;
      logic [CNT_W:0]   cur_idle;
      logic [CNT_W:0]   delta_idle;
      logic [FRAC_W:0]  quo;
      share_type        r;
      r = '0;
      if (!s.counters_valid) return r;
      cur_idle  = {1'b0, s.idle_ticks} + {1'b0, s.iowait_ticks};
      cur_total = {3'b0, s.user_ticks} + {3'b0, s.nice_ticks} + {3'b0, s.system_ticks}
                  + {2'b0, cur_idle};
      if (!have_last || cur_total <= last_total) begin
         last_total = cur_total;
         last_idle  = cur_idle;
         have_last  = 1'b1;
         return r;
      end
      delta_total = cur_total - last_total;
      if (cur_idle >= last_idle) begin
         delta_idle = cur_idle - last_idle;
         busy = (delta_idle >= delta_total) ? '0 : delta_total - delta_idle;
      end else begin
         busy = delta_total;
      end
      last_total = cur_total;
      last_idle  = cur_idle;
      if (busy >= delta_total) begin
         quo = FULL;
      end else begin
         // restoring long division, one quotient bit per pass
         rem = {1'b0, busy};
         quo = '0;
         for (int i = 0; i < FRAC_W; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, delta_total}) begin
               rem    = rem - {1'b0, delta_total};
               quo[0] = 1'b1;
            end
         end
      end
      r.busy_fraction = quo;
      r.computed      = 1'b1;
      return r;
   endfunction

   // accepted snapshots: advance the predictor, queue the expected result
   always @(posedge clock) begin
      snap_type  snap;
      share_type pred;
      want_type  tw;
      if (reset) begin
         last_total = '0;
         last_idle  = '0;
         have_last  = 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         snap = '{req_bus.counters_valid, req_bus.user_ticks, req_bus.nice_ticks,
                  req_bus.system_ticks, req_bus.idle_ticks, req_bus.iowait_ticks};
         pred = predict_busy_share(snap);
         tw   = table_want_q.pop_front();
         busy_share_q.push_back(tw.typed ? tw.share : pred);
      end
   end

   always @(posedge clock) begin
      share_type exp_share;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (busy_share_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_bus.busy_fraction, 0);
         end else begin
            exp_share = busy_share_q.pop_front();
            if (rsp_bus.busy_fraction !== exp_share.busy_fraction)
               report_mismatch("busy_fraction", rsp_bus.busy_fraction,
                               exp_share.busy_fraction);
            if (rsp_bus.computed !== exp_share.computed)
               report_mismatch("computed", rsp_bus.computed, exp_share.computed);
         end
         results_seen <= results_seen + 1;
      end
   end

   // result side: random stalls, a quiet window, and one long hold-off
   initial begin
      int  hold_cycles;
      bit  hold_done;
      hold_cycles = 0;
      hold_done   = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && results_seen >= 900) begin
            hold_done   = 1'b1;
            hold_cycles = 300;
            rsp_bus.ready <= 1'b0;
         end else if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (results_seen >= 420 && results_seen < 620) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   task automatic offer_snapshot(input snap_type s, input want_type w, input bit may_idle);
      table_want_q.push_back(w);
      if (may_idle && $urandom_range(99) < 25) begin
         repeat ($urandom_range(1, 30)) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid          <= 1'b1;
      req_bus.counters_valid <= s.counters_valid;
      req_bus.user_ticks     <= s.user_ticks;
      req_bus.nice_ticks     <= s.nice_ticks;
      req_bus.system_ticks   <= s.system_ticks;
      req_bus.idle_ticks     <= s.idle_ticks;
      req_bus.iowait_ticks   <= s.iowait_ticks;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic cnt_type rand_ticks();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[CNT_W-1:0];
   endfunction

   initial begin
      cnt_type     run_cnt [5];
      snap_type    s;
      want_type    no_want;
      int          mode;
      int unsigned lim;
      no_want = '0;
      reset <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.counters_valid <= 1'b0;
      req_bus.user_ticks     <= '0;
      req_bus.nice_ticks     <= '0;
      req_bus.system_ticks   <= '0;
      req_bus.idle_ticks     <= '0;
      req_bus.iowait_ticks   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_N; r++)
         offer_snapshot(PLAN[r].snap, PLAN[r].want, 1'b1);

      for (int k = 0; k < 5; k++) run_cnt[k] = '0;
      for (int n = 0; n < RANDOM_N; n++) begin
         mode = $urandom_range(99);
         s.counters_valid = 1'b1;
         if (mode < 65) begin
            // counters moving forward, mostly at a plausible rate
            case ($urandom_range(9))
               0:       lim = 0;
               1, 2, 3: lim = 20;
               4, 5, 6: lim = 1000;
               default: lim = 1 << 20;
            endcase
            for (int k = 0; k < 5; k++)
               run_cnt[k] = run_cnt[k] + cnt_type'($urandom_range(0, lim));
            if ($urandom_range(9) == 0)
               run_cnt[$urandom_range(4)] += rand_ticks() >> $urandom_range(47);
         end else if (mode < 75) begin
            s.counters_valid = 1'b0;
         end else if (mode < 85) begin
            for (int k = 0; k < 5; k++) run_cnt[k] = rand_ticks();
         end else if (mode < 93) begin
            // idle runs backwards, total may or may not still grow
            run_cnt[3 + $urandom_range(1)] -= cnt_type'($urandom_range(1, 500));
            run_cnt[$urandom_range(2)]     += cnt_type'($urandom_range(0, 1000));
         end else begin
            for (int k = 0; k < 5; k++)
               run_cnt[k] = MAXC - cnt_type'($urandom_range(0, 1000));
         end
         if (s.counters_valid) begin
            s.user_ticks   = run_cnt[0];
            s.nice_ticks   = run_cnt[1];
            s.system_ticks = run_cnt[2];
            s.idle_ticks   = run_cnt[3];
            s.iowait_ticks = run_cnt[4];
         end else begin
            s.user_ticks   = rand_ticks();
            s.nice_ticks   = rand_ticks();
            s.system_ticks = rand_ticks();
            s.idle_ticks   = rand_ticks();
            s.iowait_ticks = rand_ticks();
         end
         offer_snapshot(s, no_want, !(n >= 400 && n < 600));
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (busy_share_q.size() != 0) @(posedge clock);
      repeat (FRAC_W + 20) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
